[hw/rtl/srsw_pkg.sv]
`default_nettype none
package srsw_pkg;

   localparam int WINDOW_DEF = 64;
   localparam int SEQ_BITS   = 24;

   localparam logic [22:0] ONE_FX     = 23'd65536;
   localparam logic [15:0] CKSUM_MASK = 16'hFFFF;

   localparam logic [23:0] TOTAL_RST   = 24'd1;
   localparam logic [31:0] TIMEOUT_RST = 32'd1000;
   localparam logic [6:0]  THR_RST     = 7'd64;

   localparam logic [1:0] REG_TOTAL   = 2'd0;
   localparam logic [1:0] REG_TIMEOUT = 2'd1;
   localparam logic [1:0] REG_THRESH  = 2'd2;

   localparam logic OP_TICK = 1'b0;
   localparam logic OP_ACK  = 1'b1;

   localparam logic [2:0] KIND_SEND    = 3'd0;
   localparam logic [2:0] KIND_TIMEOUT = 3'd1;
   localparam logic [2:0] KIND_ACK_OK  = 3'd2;
   localparam logic [2:0] KIND_CORRUPT = 3'd3;
   localparam logic [2:0] KIND_UNSENT  = 3'd4;

   typedef enum logic [3:0] {
      ST_IDLE,
      ST_ACK,
      ST_SLIDE,
      ST_TSTART,
      ST_TREAD,
      ST_TEVAL,
      ST_GROW,
      ST_DIVW,
      ST_AEMIT,
      ST_FIN
   } state_type;

endpackage
`default_nettype wire

[hw/rtl/srsw_recip.sv]
`default_nettype none
module srsw_recip import srsw_pkg::*; (
   input  wire logic        clock,
   input  wire logic        reset,
   input  wire logic        start,
   input  wire logic [6:0]  divisor,
   output logic             done,
   output logic [16:0]      quotient
);

   // restoring division of 65536 by divisor, one quotient bit a cycle
   logic        run_ff, run_in;
   logic        done_ff, done_in;
   logic [4:0]  cnt_ff, cnt_in;
   logic [6:0]  rem_ff, rem_in;
   logic [16:0] q_ff, q_in;
   logic [6:0]  d_ff, d_in;
   logic [7:0]  trial;

   always_comb begin
      run_in  = run_ff;
      done_in = 1'b0;
      cnt_in  = cnt_ff;
      rem_in  = rem_ff;
      q_in    = q_ff;
      d_in    = d_ff;
      trial   = {rem_ff, (cnt_ff == 5'd0)};
      if (start) begin
         run_in = 1'b1;
         cnt_in = 5'd0;
         rem_in = 7'd0;
         q_in   = 17'd0;
         d_in   = divisor;
      end else if (run_ff) begin
         if (trial >= {1'b0, d_ff}) begin
            rem_in = 7'(trial - {1'b0, d_ff});
            q_in   = {q_ff[15:0], 1'b1};
         end else begin
            rem_in = trial[6:0];
            q_in   = {q_ff[15:0], 1'b0};
         end
         cnt_in = cnt_ff + 5'd1;
         if (cnt_ff == 5'd16) begin
            run_in  = 1'b0;
            done_in = 1'b1;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         run_ff  <= 1'b0;
         done_ff <= 1'b0;
      end else begin
         run_ff  <= run_in;
         done_ff <= done_in;
      end
      cnt_ff <= cnt_in;
      rem_ff <= rem_in;
      q_ff   <= q_in;
      d_ff   <= d_in;
   end

   assign done     = done_ff;
   assign quotient = q_ff;

endmodule
`default_nettype wire

[hw/rtl/selective_repeat_sender_window_top.sv]
`default_nettype none
// tick: the base first slides past acked packets, then each window slot in turn takes a
// send time memory read, then an evaluate step, until the window end or a timeout
// ack: a rejected ack goes straight to finish; an accepted one slides the window, and waits
// on the divider when the window grows by 1/cwnd; the final result is out in the cycle busy falls
// at most one result a cycle, and results may come back to back; the receiver cannot stall
// synchronous reset clears window state and marks at once; send times need no clearing
module selective_repeat_sender_window_top import srsw_pkg::*; #(
   parameter int WINDOW = WINDOW_DEF
) (
   input  wire logic        clock,
   input  wire logic        reset,
   input  wire logic        start,
   output logic             busy,
   input  wire logic        req_op,
   input  wire logic [31:0] req_now,
   input  wire logic [15:0] req_ack_length,
   input  wire logic [23:0] req_ack_number,
   input  wire logic [15:0] req_ack_checksum,
   output logic             rsp_valid,
   output logic [2:0]       rsp_kind,
   output logic [23:0]      rsp_packet_number,
   output logic [23:0]      rsp_base_out,
   output logic [22:0]      rsp_cwnd_out,
   output logic [6:0]       rsp_threshold_out,
   output logic             rsp_transfer_done,
   output logic             rsp_last,
   input  wire logic        csr_valid,
   output logic             csr_ready,
   input  wire logic [1:0]  csr_index,
   input  wire logic [31:0] csr_data
);

   localparam int SW = (WINDOW > 1) ? $clog2(WINDOW) : 1;
   localparam logic [SW-1:0]  SLOT_MAX = SW'(WINDOW - 1);
   localparam logic [6:0]     WIN7     = 7'(WINDOW);
   localparam logic [22:0]    CAP      = 23'(WINDOW * 65536);

   state_type state_ff, state_in;

   logic [23:0]       total_ff, total_in;
   logic [31:0]       tmo_ff, tmo_in;
   logic [23:0]       base_ff, base_in;
   logic [SW-1:0]     bslot_ff, bslot_in;
   logic [23:0]       wlast_ff, wlast_in;
   logic [22:0]       cwnd_ff, cwnd_in;
   logic [6:0]        thr_ff, thr_in;
   logic [WINDOW-1:0] sent_ff, sent_in;
   logic [WINDOW-1:0] acked_ff, acked_in;
   logic [23:0]       idx_ff, idx_in;
   logic [SW-1:0]     cslot_ff, cslot_in;
   logic              op_ff, op_in;
   logic [31:0]       now_ff, now_in;
   logic [15:0]       len_ff, len_in;
   logic [23:0]       ackno_ff, ackno_in;
   logic [15:0]       cks_ff, cks_in;

   // send time memory
   logic [31:0] times_mem [WINDOW];
   logic [31:0] rd_data_ff;
   logic        mem_we;

   // one result held back so the final one can carry last
   logic        pend_ff, pend_in;
   logic [2:0]  pkind_ff, pkind_in;
   logic [23:0] ppkt_ff, ppkt_in;
   logic [23:0] pbase_ff, pbase_in;
   logic [22:0] pcwnd_ff, pcwnd_in;
   logic [6:0]  pthr_ff, pthr_in;
   logic        pdone_ff, pdone_in;

   logic        ov_ff, ov_in;
   logic [2:0]  okind_ff, okind_in;
   logic [23:0] opkt_ff, opkt_in;
   logic [23:0] obase_ff, obase_in;
   logic [22:0] ocwnd_ff, ocwnd_in;
   logic [6:0]  othr_ff, othr_in;
   logic        odone_ff, odone_in;
   logic        olast_ff, olast_in;

   logic        gen;
   logic [2:0]  gen_kind;
   logic [23:0] gen_pkt;
   logic [22:0] gen_cwnd;
   logic [6:0]  gen_thr;

   logic        div_start, div_done;
   logic [16:0] div_q;

   logic        accept;
   logic [24:0] ck_sum;
   logic [16:0] ck_f1;
   logic [16:0] ck_f2;
   logic        ck_ok;
   logic [23:0] adiff;
   logic [SW:0] aslot_sum;
   logic [SW-1:0] aslot;
   logic        slide_go;
   logic [24:0] wend;
   logic [23:0] wlast_calc;
   logic [23:0] grow_sum;
   logic [31:0] age;
   logic [6:0]  cfg_thr;

   srsw_recip u_recip (
      .clock    (clock),
      .reset    (reset),
      .start    (div_start),
      .divisor  (cwnd_ff[22:16]),
      .done     (div_done),
      .quotient (div_q)
   );

   assign accept    = start && !busy;
   assign busy      = (state_ff != ST_IDLE);
   assign csr_ready = (state_ff == ST_IDLE);

   // ones' complement fold of length plus ack number
   assign ck_sum = 25'(len_ff) + 25'(ackno_ff);
   assign ck_f1  = 17'(ck_sum[15:0]) + 17'(ck_sum[24:16]);
   assign ck_f2  = 17'(ck_f1[15:0]) + 17'(ck_f1[16]);
   assign ck_ok  = ((~ck_f2[15:0]) & CKSUM_MASK) == cks_ff;

   assign adiff     = ackno_ff - base_ff;
   assign aslot_sum = {1'b0, bslot_ff} + (SW+1)'(adiff[SW-1:0]);
   assign aslot     = (aslot_sum > (SW+1)'(SLOT_MAX)) ? SW'(aslot_sum - (SW+1)'(WINDOW))
                                                      : aslot_sum[SW-1:0];

   assign slide_go = (base_ff <= wlast_ff) && (base_ff < total_ff) && acked_ff[bslot_ff];

   assign wend = 25'(base_ff) + 25'(cwnd_ff[22:16]) - 25'd1;
   always_comb begin
      if (total_ff == 24'd0) begin
         wlast_calc = base_ff;
      end else if (wend < 25'(total_ff - 24'd1)) begin
         wlast_calc = wend[23:0];
      end else begin
         wlast_calc = total_ff - 24'd1;
      end
   end

   assign age = now_ff - rd_data_ff;

   always_comb begin
      cfg_thr = csr_data[6:0];
      if (cfg_thr == 7'd0) begin
         cfg_thr = 7'd1;
      end else if (cfg_thr > WIN7) begin
         cfg_thr = WIN7;
      end
   end

   // next state
   always_comb begin
      state_in = state_ff;
      unique case (state_ff)
         ST_IDLE: begin
            if (accept) begin
               state_in = (req_op == OP_ACK) ? ST_ACK : ST_SLIDE;
            end
         end
         ST_ACK: begin
            if (!ck_ok || ackno_ff < base_ff || adiff >= 24'(WINDOW) || !sent_ff[aslot]) begin
               state_in = ST_FIN;
            end else begin
               state_in = ST_SLIDE;
            end
         end
         ST_SLIDE: begin
            if (!slide_go) begin
               state_in = (op_ff == OP_ACK) ? ST_GROW : ST_TSTART;
            end
         end
         ST_TSTART: state_in = (base_ff >= total_ff) ? ST_FIN : ST_TREAD;
         ST_TREAD:  state_in = (idx_ff > wlast_ff) ? ST_FIN : ST_TEVAL;
         ST_TEVAL: begin
            if (sent_ff[cslot_ff] && !acked_ff[cslot_ff] && age > tmo_ff) begin
               state_in = ST_FIN;
            end else begin
               state_in = ST_TREAD;
            end
         end
         ST_GROW: begin
            state_in = ((cwnd_ff < {thr_ff, 16'd0})) ? ST_AEMIT : ST_DIVW;
         end
         ST_DIVW:  state_in = div_done ? ST_AEMIT : ST_DIVW;
         ST_AEMIT: state_in = ST_FIN;
         ST_FIN:   state_in = ST_IDLE;
         default:  state_in = ST_IDLE;
      endcase
   end

   // datapath
   always_comb begin
      total_in  = total_ff;
      tmo_in    = tmo_ff;
      base_in   = base_ff;
      bslot_in  = bslot_ff;
      wlast_in  = wlast_ff;
      cwnd_in   = cwnd_ff;
      thr_in    = thr_ff;
      sent_in   = sent_ff;
      acked_in  = acked_ff;
      idx_in    = idx_ff;
      cslot_in  = cslot_ff;
      op_in     = op_ff;
      now_in    = now_ff;
      len_in    = len_ff;
      ackno_in  = ackno_ff;
      cks_in    = cks_ff;
      mem_we    = 1'b0;
      div_start = 1'b0;
      gen       = 1'b0;
      gen_kind  = KIND_SEND;
      gen_pkt   = idx_ff;
      gen_cwnd  = cwnd_ff;
      gen_thr   = thr_ff;
      grow_sum  = 24'(cwnd_ff) + 24'(ONE_FX);

      if (csr_valid && csr_ready) begin
         case (csr_index)
            REG_TOTAL:   total_in = csr_data[23:0];
            REG_TIMEOUT: tmo_in   = csr_data;
            REG_THRESH:  thr_in   = cfg_thr;
            default: ;
         endcase
      end

      unique case (state_ff)
         ST_IDLE: begin
            if (accept) begin
               op_in    = req_op;
               now_in   = req_now;
               len_in   = req_ack_length;
               ackno_in = req_ack_number;
               cks_in   = req_ack_checksum;
            end
         end
         ST_ACK: begin
            gen_pkt = ackno_ff;
            if (!ck_ok) begin
               gen      = 1'b1;
               gen_kind = KIND_CORRUPT;
            end else if (ackno_ff < base_ff) begin
               gen = 1'b0;
            end else if (adiff >= 24'(WINDOW) || !sent_ff[aslot]) begin
               gen      = 1'b1;
               gen_kind = KIND_UNSENT;
            end else begin
               acked_in[aslot] = 1'b1;
            end
         end
         ST_SLIDE: begin
            if (slide_go) begin
               acked_in[bslot_ff] = 1'b0;
               sent_in[bslot_ff]  = 1'b0;
               base_in  = base_ff + 24'd1;
               bslot_in = (bslot_ff == SLOT_MAX) ? '0 : bslot_ff + SW'(1);
            end
         end
         ST_TSTART: begin
            // a finished transfer keeps its window end
            if (base_ff < total_ff) begin
               wlast_in = wlast_calc;
            end
            idx_in   = base_ff;
            cslot_in = bslot_ff;
         end
         ST_TREAD: ;
         ST_TEVAL: begin
            if (!sent_ff[cslot_ff] && !acked_ff[cslot_ff]) begin
               sent_in[cslot_ff] = 1'b1;
               mem_we   = 1'b1;
               gen      = 1'b1;
               gen_kind = KIND_SEND;
            end else if (sent_ff[cslot_ff] && !acked_ff[cslot_ff] && age > tmo_ff) begin
               sent_in  = '0;
               thr_in   = 7'((24'(cwnd_ff) + 24'h1FFFF) >> 17);
               cwnd_in  = ONE_FX;
               wlast_in = base_ff;
               gen      = 1'b1;
               gen_kind = KIND_TIMEOUT;
               gen_cwnd = ONE_FX;
               gen_thr  = 7'((24'(cwnd_ff) + 24'h1FFFF) >> 17);
            end
            idx_in   = idx_ff + 24'd1;
            cslot_in = (cslot_ff == SLOT_MAX) ? '0 : cslot_ff + SW'(1);
         end
         ST_GROW: begin
            if (cwnd_ff < {thr_ff, 16'd0}) begin
               cwnd_in = (grow_sum > 24'(CAP)) ? CAP : grow_sum[22:0];
            end else begin
               div_start = 1'b1;
            end
         end
         ST_DIVW: begin
            grow_sum = 24'(cwnd_ff) + 24'(div_q);
            if (div_done) begin
               cwnd_in = (grow_sum > 24'(CAP)) ? CAP : grow_sum[22:0];
            end
         end
         ST_AEMIT: begin
            wlast_in = wlast_calc;
            gen      = 1'b1;
            gen_kind = KIND_ACK_OK;
            gen_pkt  = ackno_ff;
         end
         ST_FIN: ;
         default: ;
      endcase
   end

   // result staging
   always_comb begin
      pend_in  = pend_ff;
      pkind_in = pkind_ff;
      ppkt_in  = ppkt_ff;
      pbase_in = pbase_ff;
      pcwnd_in = pcwnd_ff;
      pthr_in  = pthr_ff;
      pdone_in = pdone_ff;
      ov_in    = 1'b0;
      okind_in = pkind_ff;
      opkt_in  = ppkt_ff;
      obase_in = pbase_ff;
      ocwnd_in = pcwnd_ff;
      othr_in  = pthr_ff;
      odone_in = pdone_ff;
      olast_in = 1'b0;
      if (gen) begin
         ov_in    = pend_ff;
         pend_in  = 1'b1;
         pkind_in = gen_kind;
         ppkt_in  = gen_pkt;
         pbase_in = base_ff;
         pcwnd_in = gen_cwnd;
         pthr_in  = gen_thr;
         pdone_in = (base_ff >= total_ff);
      end else if (state_ff == ST_FIN) begin
         ov_in    = pend_ff;
         olast_in = 1'b1;
         pend_in  = 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (mem_we) begin
         times_mem[cslot_ff] <= now_ff;
      end
      rd_data_ff <= times_mem[cslot_ff];
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= ST_IDLE;
         total_ff <= TOTAL_RST;
         tmo_ff   <= TIMEOUT_RST;
         base_ff  <= '0;
         bslot_ff <= '0;
         wlast_ff <= '0;
         cwnd_ff  <= ONE_FX;
         thr_ff   <= (THR_RST > WIN7) ? WIN7 : THR_RST;
         sent_ff  <= '0;
         acked_ff <= '0;
         pend_ff  <= 1'b0;
         ov_ff    <= 1'b0;
      end else begin
         state_ff <= state_in;
         total_ff <= total_in;
         tmo_ff   <= tmo_in;
         base_ff  <= base_in;
         bslot_ff <= bslot_in;
         wlast_ff <= wlast_in;
         cwnd_ff  <= cwnd_in;
         thr_ff   <= thr_in;
         sent_ff  <= sent_in;
         acked_ff <= acked_in;
         pend_ff  <= pend_in;
         ov_ff    <= ov_in;
      end
      idx_ff   <= idx_in;
      cslot_ff <= cslot_in;
      op_ff    <= op_in;
      now_ff   <= now_in;
      len_ff   <= len_in;
      ackno_ff <= ackno_in;
      cks_ff   <= cks_in;
      pkind_ff <= pkind_in;
      ppkt_ff  <= ppkt_in;
      pbase_ff <= pbase_in;
      pcwnd_ff <= pcwnd_in;
      pthr_ff  <= pthr_in;
      pdone_ff <= pdone_in;
      okind_ff <= okind_in;
      opkt_ff  <= opkt_in;
      obase_ff <= obase_in;
      ocwnd_ff <= ocwnd_in;
      othr_ff  <= othr_in;
      odone_ff <= odone_in;
      olast_ff <= olast_in;
   end

   assign rsp_valid         = ov_ff;
   assign rsp_kind          = okind_ff;
   assign rsp_packet_number = opkt_ff;
   assign rsp_base_out      = obase_ff;
   assign rsp_cwnd_out      = ocwnd_ff;
   assign rsp_threshold_out = othr_ff;
   assign rsp_transfer_done = odone_ff;
   assign rsp_last          = olast_ff;

endmodule
`default_nettype wire

[hw/rtl/srsw_checker.sv]
`default_nettype none
module srsw_checker import srsw_pkg::*; (
   input wire logic       clock,
   input wire logic       reset,
   input wire logic       start,
   input wire logic       busy,
   input wire logic       rsp_valid,
   input wire logic [2:0] rsp_kind,
   input wire logic       rsp_last
);

   // an accepted word raises busy in the next cycle
   a_accept_busy: assert property (@(posedge clock) disable iff (reset)
      start && !busy |=> busy)
      else $error("accepted word did not raise busy");

   // nothing follows the final result of a word right away
   a_last_gap: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_last |=> !rsp_valid)
      else $error("result right after last");

   // timeouts and ack results always close their word
   a_single_last: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_kind != KIND_SEND |-> rsp_last)
      else $error("non-send result without last");

   a_reset_idle: assert property (@(posedge clock)
      reset |=> !busy && !rsp_valid)
      else $error("busy after reset");

endmodule

bind selective_repeat_sender_window_top srsw_checker u_srsw_checker (
   .clock     (clock),
   .reset     (reset),
   .start     (start),
   .busy      (busy),
   .rsp_valid (rsp_valid),
   .rsp_kind  (rsp_kind),
   .rsp_last  (rsp_last)
);
`default_nettype wire

[bench/selective_repeat_sender_window_top_test.sv]
`default_nettype none
module selective_repeat_sender_window_top_test;
   import srsw_pkg::*;
   timeunit 1ns;
   timeprecision 1ps;

   localparam int WIN = 64;

   typedef struct {
      logic        op;
      logic [31:0] now;
      logic [15:0] len;
      logic [23:0] ackno;
      logic [15:0] cks;
   } req_word_type;

   typedef struct {
      logic [2:0]  kind;
      logic [23:0] pkt;
      logic [23:0] base;
      logic [22:0] cwnd;
      logic [6:0]  thr;
      logic        done;
      logic        last;
   } rsp_word_type;

   logic        clock = 1'b0;
   logic        reset = 1'b1;
   logic        start = 1'b0;
   logic        busy;
   logic        req_op = OP_TICK;
   logic [31:0] req_now = '0;
   logic [15:0] req_ack_length = '0;
   logic [23:0] req_ack_number = '0;
   logic [15:0] req_ack_checksum = '0;
   logic        rsp_valid;
   logic [2:0]  rsp_kind;
   logic [23:0] rsp_packet_number;
   logic [23:0] rsp_base_out;
   logic [22:0] rsp_cwnd_out;
   logic [6:0]  rsp_threshold_out;
   logic        rsp_transfer_done;
   logic        rsp_last;
   logic        csr_valid = 1'b0;
   logic        csr_ready;
   logic [1:0]  csr_index = REG_TOTAL;
   logic [31:0] csr_data = '0;

   selective_repeat_sender_window_top i_dut (.*);

   always begin
      #2 clock = 1'b1;
      #2 clock = 1'b0;
   end

   // shadow of the sender window
   logic [23:0] m_total;
   logic [31:0] m_timeout;
   logic [31:0] m_base, m_last, m_cwnd, m_ssthresh;
   logic        m_sent [WIN];
   logic        m_acked [WIN];
   logic [31:0] m_stamp [WIN];

   req_word_type pending_words[$];
   rsp_word_type expected_rsps[$];
   req_word_type cur_word;
   int        idle_left = 0;
   bit        no_idle = 0;
   int        errors = 0;

   function automatic void queue_word(req_word_type w);
      pending_words = {pending_words, w};
   endfunction

   function automatic logic [31:0] clamp_thr(logic [6:0] v);
      if (v < 1) return 1;
      if (v > WIN) return WIN;
      return 32'(v);
   endfunction

   function automatic void window_slide();
      while (m_base <= m_last && m_base < m_total && m_acked[m_base % WIN]) begin
         m_acked[m_base % WIN] = 0;
         m_sent[m_base % WIN] = 0;
         m_base++;
      end
   endfunction

   function automatic void window_set_last();
      logic [31:0] e;
      if (m_total == 0) begin
         m_last = m_base;
         return;
      end
      e = m_base + (m_cwnd >> 16) - 1;
      m_last = (e < m_total - 1) ? e : m_total - 1;
   endfunction

   function automatic void push_rsp(logic [2:0] kind, logic [31:0] pkt);
      rsp_word_type r;
      r.kind = kind;
      r.pkt  = pkt[23:0];
      r.base = m_base[23:0];
      r.cwnd = m_cwnd[22:0];
      r.thr  = m_ssthresh[6:0];
      r.done = (m_base >= m_total);
      r.last = 0;
      expected_rsps = {expected_rsps, r};
   endfunction

   function automatic logic [15:0] ack_sum(logic [15:0] len, logic [23:0] ackno);
      logic [31:0] s;
      s = len + ackno;
      while (s >> 16) s = (s & 32'hFFFF) + (s >> 16);
      return ~s[15:0];
   endfunction

   function automatic void predict_window(req_word_type w);
      int n;
      logic [31:0] i, s, whole;
      n = 0;
      if (w.op == OP_TICK) begin
         window_slide();
         if (m_base >= m_total) return;
         window_set_last();
         for (i = m_base; i <= m_last && n < 64; i++) begin
            s = i % WIN;
            if (!m_sent[s] && !m_acked[s]) begin
               m_sent[s] = 1;
               m_stamp[s] = w.now;
               push_rsp(KIND_SEND, i);
               n++;
            end
            if (m_sent[s] && !m_acked[s] && (w.now - m_stamp[s]) > m_timeout) begin
               if (n >= 64) break;
               for (int k = 0; k < WIN; k++) m_sent[k] = 0;
               m_ssthresh = (m_cwnd + 32'h1FFFF) >> 17;
               m_cwnd = 32'd65536;
               m_last = m_base;
               push_rsp(KIND_TIMEOUT, i);
               n++;
               break;
            end
         end
      end else begin
         if (ack_sum(w.len, w.ackno) != w.cks) begin
            push_rsp(KIND_CORRUPT, 32'(w.ackno));
            n++;
         end else if (w.ackno < m_base) begin
            return;
         end else if (w.ackno - m_base >= WIN || !m_sent[w.ackno % WIN]) begin
            push_rsp(KIND_UNSENT, 32'(w.ackno));
            n++;
         end else begin
            m_acked[w.ackno % WIN] = 1;
            window_slide();
            if (m_cwnd < (m_ssthresh << 16)) m_cwnd += 32'd65536;
            else begin
               whole = m_cwnd >> 16;
               if (whole == 0) whole = 1;
               m_cwnd += 32'd65536 / whole;
            end
            if (m_cwnd > (WIN << 16)) m_cwnd = WIN << 16;
            window_set_last();
            push_rsp(KIND_ACK_OK, 32'(w.ackno));
            n++;
         end
      end
      if (n > 0) expected_rsps[$].last = 1;
   endfunction

   // command driver
   always @(posedge clock) begin
      if (reset) begin
         start <= 1'b0;
      end else begin
         if (start && !busy) predict_window(cur_word);
         if (!start || !busy) begin
            if (idle_left > 0) begin
               idle_left--;
               start <= 1'b0;
            end else if (pending_words.size() > 0) begin
               cur_word = pending_words.pop_front();
               req_op <= cur_word.op;
               req_now <= cur_word.now;
               req_ack_length <= cur_word.len;
               req_ack_number <= cur_word.ackno;
               req_ack_checksum <= cur_word.cks;
               start <= 1'b1;
               if (!no_idle && $urandom_range(0, 5) == 0) idle_left = $urandom_range(1, 4);
            end else begin
               start <= 1'b0;
            end
         end
      end
   end

   // result monitor
   always @(posedge clock) begin
      rsp_word_type e;
      if (!reset && rsp_valid) begin
         if (expected_rsps.size() == 0) begin
            $display("%0t: unexpected word kind %0d pkt %0d", $realtime, rsp_kind,
                     rsp_packet_number);
            errors++;
         end else begin
            e = expected_rsps.pop_front();
            if (rsp_kind !== e.kind || rsp_packet_number !== e.pkt ||
                rsp_base_out !== e.base || rsp_cwnd_out !== e.cwnd ||
                rsp_threshold_out !== e.thr || rsp_transfer_done !== e.done ||
                rsp_last !== e.last) begin
               $display("%0t: expected kind %0d pkt %0d base %0d cwnd %0d thr %0d done %0d last %0d",
                        $realtime, e.kind, e.pkt, e.base, e.cwnd, e.thr, e.done, e.last);
               $display("%0t: actual   kind %0d pkt %0d base %0d cwnd %0d thr %0d done %0d last %0d",
                        $realtime, rsp_kind, rsp_packet_number, rsp_base_out, rsp_cwnd_out,
                        rsp_threshold_out, rsp_transfer_done, rsp_last);
               errors++;
            end
         end
      end
   end

   task automatic drain_all();
      while (pending_words.size() > 0 || start || expected_rsps.size() > 0)
         @(posedge clock);
      repeat (400) @(posedge clock);
   endtask

   task automatic csr_write(logic [1:0] idx, logic [31:0] data);
      @(posedge clock);
      csr_valid <= 1'b1;
      csr_index <= idx;
      csr_data <= data;
      do @(posedge clock); while (!csr_ready);
      csr_valid <= 1'b0;
      if (idx == REG_TOTAL) m_total = data[23:0];
      else if (idx == REG_TIMEOUT) m_timeout = data;
      else m_ssthresh = clamp_thr(data[6:0]);
   endtask

   function automatic req_word_type tick_word(logic [31:0] now);
      req_word_type w;
      w.op = OP_TICK;
      w.now = now;
      w.len = 16'($urandom);
      w.ackno = 24'($urandom);
      w.cks = 16'($urandom);
      return w;
   endfunction

   function automatic req_word_type ack_word(logic [15:0] len, logic [23:0] ackno);
      req_word_type w;
      w.op = OP_ACK;
      w.now = $urandom;
      w.len = len;
      w.ackno = ackno;
      w.cks = ack_sum(len, ackno);
      return w;
   endfunction

   logic [31:0] now_ctr;

   function automatic req_word_type random_word();
      req_word_type w;
      int r;
      logic [31:0] step;
      r = $urandom_range(0, 99);
      if (r < 40) begin
         step = (m_timeout < 100000) ? $urandom_range(0, m_timeout / 3 + 1)
                                     : $urandom_range(0, 50);
         if ($urandom_range(0, 9) == 0) step = m_timeout + $urandom_range(1, 20);
         now_ctr = now_ctr + step;
         if ($urandom_range(0, 19) == 0) now_ctr = $urandom;
         w = tick_word(now_ctr);
      end else if (r < 85) begin
         w = ack_word(16'($urandom), 24'(m_base + $urandom_range(0, 70)));
      end else if (r < 90) begin
         w = ack_word(16'($urandom),
                      (m_base > 0) ? 24'(m_base - $urandom_range(1, 3)) : 24'd0);
      end else begin
         w.op = OP_ACK;
         w.now = $urandom;
         w.len = 16'($urandom);
         w.ackno = 24'($urandom);
         w.cks = 16'($urandom);
      end
      return w;
   endfunction

   initial begin
      logic [31:0] tot;
      logic [31:0] tmo;
      logic [6:0]  thr;
      req_word_type w;
      m_total = TOTAL_RST;
      m_timeout = TIMEOUT_RST;
      m_base = 0;
      m_last = 0;
      m_cwnd = 32'd65536;
      m_ssthresh = clamp_thr(THR_RST);
      for (int k = 0; k < WIN; k++) begin
         m_sent[k] = 0;
         m_acked[k] = 0;
         m_stamp[k] = 0;
      end
      now_ctr = 0;
      repeat (11) @(posedge clock);
      reset <= 1'b0;

      // defaults: single packet transfer
      queue_word(tick_word(0));
      w = ack_word(16'h0, 24'h0);
      w.cks = ~w.cks;
      queue_word(w);
      queue_word(ack_word(16'h0, 24'd5));
      queue_word(ack_word(16'hFFFF, 24'h0));
      queue_word(tick_word(32'd10));
      queue_word(ack_word(16'h1234, 24'h0));
      drain_all();

      csr_write(REG_TOTAL, m_base + 40);
      csr_write(REG_TIMEOUT, 32'd100);
      csr_write(REG_THRESH, 32'd4);
      queue_word(tick_word(32'd10));
      queue_word(ack_word(16'h0, 24'd1));
      queue_word(ack_word(16'hFFFF, 24'd2));
      queue_word(ack_word(16'h5555, 24'd1));
      queue_word(ack_word(16'h0, 24'd65));
      queue_word(tick_word(32'd20));
      queue_word(ack_word(16'h0, 24'd3));
      queue_word(tick_word(32'd500));
      queue_word(tick_word(32'd501));
      queue_word(ack_word(16'hFFFF, 24'hFFFFFF));
      w = ack_word(16'h0, 24'hFFFFFF);
      w.cks = 16'hFFFF;
      queue_word(w);
      queue_word(tick_word(32'hFFFFFFFF));
      queue_word(tick_word(32'h0));
      drain_all();
      now_ctr = 0;

      for (int ph = 0; ph < 11; ph++) begin
         tot = m_base + $urandom_range(1, 200);
         if (ph == 5) tot = 32'hFFFFFF;
         if (tot > 32'hFFFFFF) tot = 32'hFFFFFF;
         case (ph % 4)
            0: tmo = $urandom_range(5, 200);
            1: tmo = 1;
            2: tmo = 32'hFFFFFFFF;
            default: tmo = $urandom_range(20, 60);
         endcase
         case (ph % 5)
            0: thr = 7'd0;
            1: thr = 7'd1;
            2: thr = 7'd64;
            3: thr = 7'd127;
            default: thr = 7'($urandom_range(2, 63));
         endcase
         csr_write(REG_TOTAL, tot);
         csr_write(REG_TIMEOUT, tmo);
         csr_write(REG_THRESH, 32'(thr));
         no_idle = (ph >= 10);
         for (int b = 0; b < 5; b++) begin
            for (int j = 0; j < 8; j++) queue_word(random_word());
            while (pending_words.size() > 0) @(posedge clock);
            if (b == 2) drain_all();
         end
         drain_all();
      end

      if (errors == 0) $display("selective_repeat_sender_window_top_test: done, clean");
      else $display("selective_repeat_sender_window_top_test: done, errors");
      $finish;
   end

   initial begin
      #20ms;
      $display("selective_repeat_sender_window_top_test: done, errors");
      $finish;
   end

endmodule
`default_nettype wire

[filelist.f]
hw/rtl/srsw_pkg.sv
hw/rtl/srsw_recip.sv
hw/rtl/selective_repeat_sender_window_top.sv
hw/rtl/srsw_checker.sv
bench/selective_repeat_sender_window_top_test.sv
